// ===== rtl/bta_pkg.sv =====
package bta_pkg;

    // Default depth of the tag store in 4-byte words (a power of two).
    localparam int HEAP_WORDS_DEF = 16384;

    localparam int TAG_W    = 18;
    localparam int CHUNK_W  = 17;
    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int STATUS_W = 2;
    localparam int ASIZE_W  = 17;

    localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd4096;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OOM  = 2'd2;

    // Tags laid down when the heap is built.
    localparam logic [TAG_W-1:0] TAG_PAD      = 18'd0;
    localparam logic [TAG_W-1:0] TAG_PROLOGUE = 18'd9;
    localparam logic [TAG_W-1:0] TAG_EPILOGUE = 18'd1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INIT,
        S_DISPATCH,
        S_WALK_RD,
        S_WALK_CHK,
        S_GROW_CHK,
        S_GROW_WR,
        S_MRG_R0,
        S_MRG_R1,
        S_MRG_R2,
        S_MRG_R3,
        S_MRG_R4,
        S_MRG_R5,
        S_MRG_W1,
        S_MRG_W2,
        S_MRG_END,
        S_CARVE_RD,
        S_CARVE_CHK,
        S_CARVE_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_WR,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        CALL_INIT,
        CALL_ALLOC,
        CALL_FREE
    } caller_t;

endpackage

// ===== rtl/bta_req_if.sv =====
interface bta_req_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [bta_pkg::REQ_W-1:0]   request_bytes;
    logic [bta_pkg::ADDR_W-1:0]  block_address;

    modport source (output valid, mode, request_bytes, block_address, input ready);
    modport sink   (input valid, mode, request_bytes, block_address, output ready);
endinterface

// ===== rtl/bta_rsp_if.sv =====
interface bta_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bta_pkg::ADDR_W-1:0]    payload_address;
    logic [bta_pkg::STATUS_W-1:0]  status;

    modport source (output valid, payload_address, status, input ready);
    modport sink   (input valid, payload_address, status, output ready);
endinterface

// ===== rtl/boundary_tag_heap_allocator.sv =====
// Boundary-tag heap allocator with an implicit free list and first-fit placement. Each beat on
// req either allocates (mode 0, request_bytes) or frees (mode 1, block_address) and produces
// exactly one beat on rsp. All tags live in a single-port synchronous memory of HEAP_WORDS
// words (HEAP_WORDS must be a power of two) which is read and written one word per cycle, and
// that one port sets the rate: one item is in work at a time. The first beat after reset first
// builds the heap: the padding word, prologue and epilogue tags, then a first chunk if it fits.
// An allocation walks the blocks first-fit, grows the heap and merges the new block when none
// fits, then marks the block used and splits it when the rest is at least 16 bytes; a free marks
// the block free and merges it with free neighbours. Every item is accepted in the idle state
// and hands its result over from the completion state. The tag memory needs no clearing pass
// after reset. A finished result waits in an output register, and the next request beat is
// accepted while it waits.
module boundary_tag_heap_allocator #(
    parameter int HEAP_WORDS = bta_pkg::HEAP_WORDS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bta_pkg::CHUNK_W-1:0]    cfg_wr_data,
    bta_req_if.sink                        req,
    bta_rsp_if.source                      rsp
);

    // Word index bits, byte address bits (taken modulo the store), break width, and a
    // position width wide enough for a break plus any tag size.
    localparam int LW = $clog2(HEAP_WORDS);
    localparam int AW = LW + 2;
    localparam int BW = AW + 1;
    localparam int PW = ((AW > bta_pkg::TAG_W) ? AW : bta_pkg::TAG_W) + 1;
    localparam logic [PW-1:0] HEAP_BYTES = PW'(64'(HEAP_WORDS) * 64'd4);

    localparam int TW = bta_pkg::TAG_W;
    localparam int SW = TW + 2;

    // Control state.
    bta_pkg::state_t              state_reg, state_next;
    logic [1:0]                   cnt_reg, cnt_next;
    logic                         init_done_reg, init_done_next;
    logic [BW-1:0]                break_reg, break_next;
    logic [bta_pkg::CHUNK_W-1:0]  chunk_reg;
    logic                         out_valid_reg, out_valid_next;

    // Working registers.
    logic                         mode_reg, mode_next;
    logic [bta_pkg::REQ_W-1:0]    req_bytes_reg, req_bytes_next;
    logic [bta_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [bta_pkg::ASIZE_W-1:0]  asize_reg, asize_next;
    logic [PW-1:0]                p_reg, p_next;
    logic [PW-1:0]                mbp_reg, mbp_next;
    logic [PW-1:0]                mret_reg, mret_next;
    bta_pkg::caller_t             caller_reg, caller_next;
    logic [TW-1:0]                msize_reg, msize_next;
    logic [TW-1:0]                pf_reg, pf_next;
    logic [TW-1:0]                nh_reg, nh_next;
    logic [TW-1:0]                wsize_reg, wsize_next;
    logic [AW-1:0]                wa1_reg, wa1_next;
    logic [AW-1:0]                wa2_reg, wa2_next;
    logic [TW-1:0]                gbytes_reg, gbytes_next;
    logic [TW-1:0]                cur_reg, cur_next;
    logic                         split_reg, split_next;
    logic [bta_pkg::ADDR_W-1:0]   res_pay_reg, res_pay_next;
    logic [bta_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [bta_pkg::ADDR_W-1:0]   out_pay_reg, out_pay_next;
    logic [bta_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // Tag memory port.
    logic [TW-1:0]                tag_mem [HEAP_WORDS];
    logic [TW-1:0]                rdata_reg;
    logic                         mem_we;
    logic [AW-1:0]                mem_ba;
    logic [TW-1:0]                mem_wdata;

    // Derived values.
    logic                         in_acc;
    logic [TW-1:0]                rd_size;
    logic                         rd_used;
    logic [TW-1:0]                nh_size;
    logic [bta_pkg::CHUNK_W-1:0]  chunk_floor;
    logic [TW-1:0]                chunk_eff;
    logic [bta_pkg::ASIZE_W-1:0]  asize_calc;
    logic [TW-1:0]                grow_ext;
    logic [PW-1:0]                prev_bp;
    logic [SW-1:0]                sum2;
    logic [SW-1:0]                sum3;
    logic [TW-1:0]                rest;
    logic [TW-1:0]                asize_tag;
    logic [AW-1:0]                mbp_a;
    logic [AW-1:0]                p_a;

    assign in_acc      = req.valid && req.ready;
    assign req.ready   = (state_reg == bta_pkg::S_IDLE);
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload_address = out_pay_reg;
    assign rsp.status  = out_status_reg;

    // A tag holds the block size in bytes with the allocated flag in bit 0.
    assign rd_size     = {rdata_reg[TW-1:3], 3'b000};
    assign rd_used     = rdata_reg[0];
    assign nh_size     = {nh_reg[TW-1:3], 3'b000};

    // The chunk in effect is at least 16 bytes and a multiple of 8.
    assign chunk_floor = (chunk_reg < bta_pkg::CHUNK_W'(16)) ? bta_pkg::CHUNK_W'(16) : chunk_reg;
    assign chunk_eff   = (TW'(chunk_floor) + TW'(7)) & ~TW'(7);

    // Request rounded up to 8-byte units plus 8 bytes of tags, 16 bytes minimum.
    assign asize_calc  = (req_bytes_reg <= bta_pkg::REQ_W'(8)) ? bta_pkg::ASIZE_W'(16)
                       : (bta_pkg::ASIZE_W'(req_bytes_reg) + bta_pkg::ASIZE_W'(15))
                         & ~bta_pkg::ASIZE_W'(7);
    assign grow_ext    = (TW'(asize_reg) > chunk_eff) ? TW'(asize_reg) : chunk_eff;

    assign prev_bp     = mbp_reg - PW'({pf_reg[TW-1:3], 3'b000});
    assign sum2        = SW'(msize_reg) + SW'(rd_size);
    assign sum3        = sum2 + SW'(nh_size);
    assign rest        = cur_reg - TW'(asize_reg);
    assign asize_tag   = TW'(asize_reg) | TW'(1);
    assign mbp_a       = mbp_reg[AW-1:0];
    assign p_a         = p_reg[AW-1:0];

    // Tag memory: one access per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_ba[AW-1:2]] <= mem_wdata;
        end
        else
        begin
            rdata_reg <= tag_mem[mem_ba[AW-1:2]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bta_pkg::S_IDLE;
            cnt_reg       <= 2'd0;
            init_done_reg <= 1'b0;
            break_reg     <= '0;
            chunk_reg     <= bta_pkg::CHUNK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            init_done_reg <= init_done_next;
            break_reg     <= break_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                chunk_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        req_bytes_reg  <= req_bytes_next;
        addr_reg       <= addr_next;
        asize_reg      <= asize_next;
        p_reg          <= p_next;
        mbp_reg        <= mbp_next;
        mret_reg       <= mret_next;
        caller_reg     <= caller_next;
        msize_reg      <= msize_next;
        pf_reg         <= pf_next;
        nh_reg         <= nh_next;
        wsize_reg      <= wsize_next;
        wa1_reg        <= wa1_next;
        wa2_reg        <= wa2_next;
        gbytes_reg     <= gbytes_next;
        cur_reg        <= cur_next;
        split_reg      <= split_next;
        res_pay_reg    <= res_pay_next;
        res_status_reg <= res_status_next;
        out_pay_reg    <= out_pay_next;
        out_status_reg <= out_status_next;
    end

    // Sequencer: every read whose data is needed is issued in one state and its data used in the next.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        init_done_next  = init_done_reg;
        break_next      = break_reg;
        out_valid_next  = out_valid_reg;
        mode_next       = mode_reg;
        req_bytes_next  = req_bytes_reg;
        addr_next       = addr_reg;
        asize_next      = asize_reg;
        p_next          = p_reg;
        mbp_next        = mbp_reg;
        mret_next       = mret_reg;
        caller_next     = caller_reg;
        msize_next      = msize_reg;
        pf_next         = pf_reg;
        nh_next         = nh_reg;
        wsize_next      = wsize_reg;
        wa1_next        = wa1_reg;
        wa2_next        = wa2_reg;
        gbytes_next     = gbytes_reg;
        cur_next        = cur_reg;
        split_next      = split_reg;
        res_pay_next    = res_pay_reg;
        res_status_next = res_status_reg;
        out_pay_next    = out_pay_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_ba          = '0;
        mem_wdata       = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bta_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next      = req.mode;
                    req_bytes_next = req.request_bytes;
                    addr_next      = req.block_address;
                    cnt_next       = 2'd0;
                    state_next     = init_done_reg ? bta_pkg::S_DISPATCH : bta_pkg::S_INIT;
                end
            end

            // Padding word, prologue header and footer, epilogue header.
            bta_pkg::S_INIT:
            begin
                mem_we = 1'b1;
                mem_ba = AW'({cnt_reg, 2'b00});
                unique case (cnt_reg)
                    2'd0: mem_wdata = bta_pkg::TAG_PAD;
                    2'd1: mem_wdata = bta_pkg::TAG_PROLOGUE;
                    2'd2: mem_wdata = bta_pkg::TAG_PROLOGUE;
                    2'd3: mem_wdata = bta_pkg::TAG_EPILOGUE;
                    default: mem_wdata = bta_pkg::TAG_PAD;
                endcase
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    break_next  = BW'(16);
                    gbytes_next = chunk_eff;
                    caller_next = bta_pkg::CALL_INIT;
                    state_next  = bta_pkg::S_GROW_CHK;
                end
            end

            bta_pkg::S_DISPATCH:
            begin
                init_done_next  = 1'b1;
                res_pay_next    = '0;
                res_status_next = bta_pkg::STATUS_DONE;
                if (mode_reg == bta_pkg::MODE_ALLOC)
                begin
                    if (req_bytes_reg == '0)
                    begin
                        res_status_next = bta_pkg::STATUS_ZERO;
                        state_next      = bta_pkg::S_DONE;
                    end
                    else
                    begin
                        asize_next = asize_calc;
                        p_next     = PW'(8);
                        state_next = bta_pkg::S_WALK_RD;
                    end
                end
                else if ((addr_reg[2:0] == 3'd0) && (addr_reg >= bta_pkg::ADDR_W'(16))
                         && (PW'(addr_reg) < PW'(break_reg)))
                begin
                    state_next = bta_pkg::S_FREE_RD;
                end
                else
                begin
                    state_next = bta_pkg::S_DONE;
                end
            end

            bta_pkg::S_WALK_RD:
            begin
                if (p_reg < PW'(break_reg))
                begin
                    mem_ba     = p_a - AW'(4);
                    state_next = bta_pkg::S_WALK_CHK;
                end
                else
                begin
                    gbytes_next = grow_ext;
                    caller_next = bta_pkg::CALL_ALLOC;
                    state_next  = bta_pkg::S_GROW_CHK;
                end
            end

            bta_pkg::S_WALK_CHK:
            begin
                if (rd_size == '0)
                begin
                    gbytes_next = grow_ext;
                    caller_next = bta_pkg::CALL_ALLOC;
                    state_next  = bta_pkg::S_GROW_CHK;
                end
                else if (!rd_used && (rd_size >= TW'(asize_reg)))
                begin
                    state_next = bta_pkg::S_CARVE_RD;
                end
                else
                begin
                    p_next     = p_reg + PW'(rd_size);
                    state_next = bta_pkg::S_WALK_RD;
                end
            end

            bta_pkg::S_GROW_CHK:
            begin
                if (PW'(break_reg) + PW'(gbytes_reg) > HEAP_BYTES)
                begin
                    mret_next  = '0;
                    state_next = bta_pkg::S_MRG_END;
                end
                else
                begin
                    mbp_next   = PW'(break_reg);
                    break_next = break_reg + BW'(gbytes_reg);
                    cnt_next   = 2'd0;
                    state_next = bta_pkg::S_GROW_WR;
                end
            end

            // New block header and footer, then the new epilogue.
            bta_pkg::S_GROW_WR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                priority case (cnt_reg)
                    2'd0:
                    begin
                        mem_ba    = mbp_a - AW'(4);
                        mem_wdata = gbytes_reg;
                    end
                    2'd1:
                    begin
                        mem_ba    = mbp_a + AW'(gbytes_reg) - AW'(8);
                        mem_wdata = gbytes_reg;
                    end
                    default:
                    begin
                        mem_ba     = mbp_a + AW'(gbytes_reg) - AW'(4);
                        mem_wdata  = bta_pkg::TAG_EPILOGUE;
                        state_next = bta_pkg::S_MRG_R0;
                    end
                endcase
            end

            bta_pkg::S_MRG_R0:
            begin
                mem_ba     = mbp_a - AW'(4);
                state_next = bta_pkg::S_MRG_R1;
            end

            bta_pkg::S_MRG_R1:
            begin
                msize_next = rd_size;
                mem_ba     = mbp_a - AW'(8);
                state_next = bta_pkg::S_MRG_R2;
            end

            bta_pkg::S_MRG_R2:
            begin
                pf_next    = rdata_reg;
                mem_ba     = mbp_a + AW'(msize_reg) - AW'(4);
                state_next = bta_pkg::S_MRG_R3;
            end

            bta_pkg::S_MRG_R3:
            begin
                nh_next   = rdata_reg;
                mret_next = mbp_reg;
                if (pf_reg[0] && rd_used)
                begin
                    state_next = bta_pkg::S_MRG_END;
                end
                else if (pf_reg[0])
                begin
                    wsize_next = TW'(sum2);
                    wa1_next   = mbp_a - AW'(4);
                    wa2_next   = mbp_a + AW'(sum2) - AW'(8);
                    state_next = bta_pkg::S_MRG_W1;
                end
                else
                begin
                    state_next = bta_pkg::S_MRG_R4;
                end
            end

            bta_pkg::S_MRG_R4:
            begin
                mem_ba     = prev_bp[AW-1:0] - AW'(4);
                state_next = bta_pkg::S_MRG_R5;
            end

            bta_pkg::S_MRG_R5:
            begin
                mret_next = prev_bp;
                wa2_next  = prev_bp[AW-1:0] - AW'(4);
                if (nh_reg[0])
                begin
                    wsize_next = TW'(sum2);
                    wa1_next   = mbp_a + AW'(msize_reg) - AW'(8);
                end
                else
                begin
                    wsize_next = TW'(sum3);
                    wa1_next   = mbp_a + AW'(msize_reg) + AW'(nh_size) - AW'(8);
                end
                state_next = bta_pkg::S_MRG_W1;
            end

            bta_pkg::S_MRG_W1:
            begin
                mem_we     = 1'b1;
                mem_ba     = wa1_reg;
                mem_wdata  = wsize_reg;
                state_next = bta_pkg::S_MRG_W2;
            end

            bta_pkg::S_MRG_W2:
            begin
                mem_we     = 1'b1;
                mem_ba     = wa2_reg;
                mem_wdata  = wsize_reg;
                state_next = bta_pkg::S_MRG_END;
            end

            bta_pkg::S_MRG_END:
            begin
                unique case (caller_reg)
                    bta_pkg::CALL_INIT:
                    begin
                        state_next = bta_pkg::S_DISPATCH;
                    end
                    bta_pkg::CALL_ALLOC:
                    begin
                        if (mret_reg == '0)
                        begin
                            res_status_next = bta_pkg::STATUS_OOM;
                            state_next      = bta_pkg::S_DONE;
                        end
                        else
                        begin
                            p_next     = mret_reg;
                            state_next = bta_pkg::S_CARVE_RD;
                        end
                    end
                    default:
                    begin
                        state_next = bta_pkg::S_DONE;
                    end
                endcase
            end

            bta_pkg::S_CARVE_RD:
            begin
                mem_ba     = p_a - AW'(4);
                state_next = bta_pkg::S_CARVE_CHK;
            end

            bta_pkg::S_CARVE_CHK:
            begin
                cur_next     = rd_size;
                split_next   = (rd_size >= TW'(asize_reg))
                               && ((rd_size - TW'(asize_reg)) >= TW'(16));
                res_pay_next = p_reg[bta_pkg::ADDR_W-1:0];
                cnt_next     = 2'd0;
                state_next   = bta_pkg::S_CARVE_WR;
            end

            // Split: used part then the free rest; otherwise mark the whole block used.
            bta_pkg::S_CARVE_WR:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 2'd1;
                if (split_reg)
                begin
                    unique case (cnt_reg)
                        2'd0:
                        begin
                            mem_ba    = p_a - AW'(4);
                            mem_wdata = asize_tag;
                        end
                        2'd1:
                        begin
                            mem_ba    = p_a + AW'(asize_reg) - AW'(8);
                            mem_wdata = asize_tag;
                        end
                        2'd2:
                        begin
                            mem_ba    = p_a + AW'(asize_reg) - AW'(4);
                            mem_wdata = rest;
                        end
                        default:
                        begin
                            mem_ba     = p_a + AW'(cur_reg) - AW'(8);
                            mem_wdata  = rest;
                            state_next = bta_pkg::S_DONE;
                        end
                    endcase
                end
                else if (cnt_reg == 2'd0)
                begin
                    mem_ba    = p_a - AW'(4);
                    mem_wdata = cur_reg | TW'(1);
                end
                else
                begin
                    mem_ba     = p_a + AW'(cur_reg) - AW'(8);
                    mem_wdata  = cur_reg | TW'(1);
                    state_next = bta_pkg::S_DONE;
                end
            end

            bta_pkg::S_FREE_RD:
            begin
                mem_ba     = AW'(addr_reg) - AW'(4);
                state_next = bta_pkg::S_FREE_CHK;
            end

            bta_pkg::S_FREE_CHK:
            begin
                if (rd_used && (rd_size != '0)
                    && (PW'(addr_reg) + PW'(rd_size) <= PW'(break_reg)))
                begin
                    cur_next   = rd_size;
                    cnt_next   = 2'd0;
                    state_next = bta_pkg::S_FREE_WR;
                end
                else
                begin
                    state_next = bta_pkg::S_DONE;
                end
            end

            bta_pkg::S_FREE_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = cur_reg;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd0)
                begin
                    mem_ba = AW'(addr_reg) - AW'(4);
                end
                else
                begin
                    mem_ba      = AW'(addr_reg) + AW'(cur_reg) - AW'(8);
                    mbp_next    = PW'(addr_reg);
                    caller_next = bta_pkg::CALL_FREE;
                    state_next  = bta_pkg::S_MRG_R0;
                end
            end

            bta_pkg::S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_pay_next    = res_pay_reg;
                    out_status_next = res_status_reg;
                    state_next      = bta_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = bta_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The tag memory is never written while the block waits for work.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bta_pkg::S_IDLE) |-> !mem_we)
        else $error("tag memory written while idle");

    // A result only appears after the sequencer has finished an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == bta_pkg::S_DONE))
        else $error("result raised outside the completion state");

    // Once built, the heap break stays on an 8-byte boundary.
    assert property (@(posedge clk) disable iff (!rst_n)
        init_done_reg |-> (break_reg[2:0] == 3'd0))
        else $error("heap break misaligned");

    // The heap never shrinks.
    assert property (@(posedge clk) disable iff (!rst_n)
        init_done_reg |=> (break_reg >= $past(break_reg)))
        else $error("heap break moved backwards");
`endif

endmodule
